### rtl/core/lsm_pkg.sv
// Shared types, constants and the CORDIC angle table of the line segment matcher.
// No dependencies; every other file of the block imports this package.
package lsm_pkg;

  localparam int MAX_LINES_DEF = 32;

  // Field widths
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;        // endpoint difference, signed
  localparam int SUM_W    = COORD_W + 1;        // start + end, unsigned
  localparam int MID_W    = COORD_W + 2;        // midpoint difference, signed
  localparam int RAD_W    = 42;                 // squared length << 8
  localparam int LEN_W    = RAD_W / 2;          // length, 1/16 pixel
  localparam int IDX_W    = 6;
  localparam int ANGLE_W  = 23;
  localparam int COST_W   = 34;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 20;
  localparam int DOT_W        = 2 * DIFF_W + 1;
  localparam int XY_W         = DOT_W + 2;
  localparam int Z_W          = 26;
  localparam int ZC_W         = 24;
  localparam int DEG_ONE      = 65536;
  localparam logic signed [Z_W-1:0] Z_90  = Z_W'(90 * DEG_ONE);
  localparam logic signed [Z_W-1:0] Z_180 = Z_W'(180 * DEG_ONE);

  // Register reset values
  localparam logic [ANGLE_W-1:0] ANGLE_RESET    = ANGLE_W'(50 * 256);
  localparam logic [COST_W-1:0]  MIDPOINT_RESET = COST_W'(100 * 256);

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_ANGLE    = 2'd0;
  localparam logic [1:0] CFG_MIDPOINT = 2'd1;

  // One stored segment, with its length worked out at load time
  typedef struct packed {
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [LEN_W-1:0]   len;
    logic               zero;
  } entry_t;

  // Probe segment, held for the whole sweep
  typedef struct packed {
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uy;
    logic [SUM_W-1:0]         sx;
    logic [SUM_W-1:0]         sy;
    logic [LEN_W-1:0]         len;
    logic                     zero;
  } probe_t;

  // Sideband that rides along the compare pipeline
  typedef struct packed {
    logic               valid;
    logic               end_tok;
    logic               zero;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [COST_W-1:0] mc;
    logic [COST_W-1:0] lc;
  } carry_t;

  // Result of one compare, or the end-of-probe token
  typedef struct packed {
    logic               valid;
    logic               end_tok;
    logic               match;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [ANGLE_W-1:0] ac;
    logic [COST_W-1:0]  mc;
    logic [COST_W-1:0]  lc;
  } res_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic signed [Z_W-1:0] atan_deg(input int i);
    logic [21:0] v;
    case (i)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return $signed({{(Z_W-22){1'b0}}, v});
  endfunction

endpackage

### rtl/core/lsm_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on lsm_pkg for the radicand and root widths.
module lsm_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lsm_pkg::RAD_W-1:0] radicand,
  output logic                      done,
  output logic [lsm_pkg::LEN_W-1:0] root
);
  import lsm_pkg::*;

  localparam int REM_W  = LEN_W + 2;
  localparam int STEP_W = $clog2(LEN_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic              busy;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W-1:0]  rem_next;
  logic [LEN_W-1:0]  root_next;

  // One restoring step
  always_comb begin
    rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
    trial  = {{(REM_W+2-LEN_W-2){1'b0}}, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = REM_W'(rem_sh - trial);
      root_next = {root[LEN_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh[REM_W-1:0];
      root_next = {root[LEN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(LEN_W);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[RAD_W-3:0], 2'b00};
        rem  <= rem_next;
        root <= root_next;
        cnt  <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/lsm_store.sv
// Segment store: one write port and one registered read port.
// Depends on lsm_pkg for the entry type.
module lsm_store #(
  parameter int MAX_LINES = lsm_pkg::MAX_LINES_DEF,
  parameter int AW        = 5
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  lsm_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output lsm_pkg::entry_t rdata
);
  import lsm_pkg::*;

  entry_t mem [MAX_LINES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lsm_match_pipe.sv
// Compare pipeline: products, CORDIC angle, squared costs and threshold test,
// one stored segment per cycle while adv is high. Depends on lsm_pkg.
module lsm_match_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic                        in_end,
  input  logic [lsm_pkg::IDX_W-1:0]   in_idx,
  input  lsm_pkg::probe_t             probe,
  input  lsm_pkg::entry_t             entry,
  input  logic [lsm_pkg::ANGLE_W-1:0] ang_thr,
  input  logic [lsm_pkg::COST_W-1:0]  mid_thr,
  output lsm_pkg::res_t               res
);
  import lsm_pkg::*;

  localparam int ROUND_SH = 24;

  // Stage A: lines up with the store read data
  logic             a_valid;
  logic             a_end;
  logic [IDX_W-1:0] a_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      a_end   <= in_end;
      a_idx   <= in_idx;
    end
  end

  // Stage B: differences and products
  logic signed [DIFF_W-1:0] pux, puy, vx, vy;
  logic [SUM_W-1:0]         esx, esy;
  logic signed [MID_W-1:0]  dx, dy;
  logic [LEN_W:0]           ld;
  logic [LEN_W-1:0]         d_abs;
  side_t                    b_side_next;

  always_comb begin
    pux = probe.ux;
    puy = probe.uy;
    vx  = $signed({1'b0, entry.xs}) - $signed({1'b0, entry.xe});
    vy  = $signed({1'b0, entry.ys}) - $signed({1'b0, entry.ye});
    esx = {1'b0, entry.xs} + {1'b0, entry.xe};
    esy = {1'b0, entry.ys} + {1'b0, entry.ye};
    dx  = $signed({1'b0, probe.sx}) - $signed({1'b0, esx});
    dy  = $signed({1'b0, probe.sy}) - $signed({1'b0, esy});
    ld  = {1'b0, probe.len} - {1'b0, entry.len};
    d_abs = ld[LEN_W] ? LEN_W'(-ld) : ld[LEN_W-1:0];
    b_side_next.valid   = a_valid;
    b_side_next.end_tok = a_end;
    b_side_next.zero    = probe.zero | entry.zero;
    b_side_next.idx     = a_idx;
    b_side_next.xs      = entry.xs;
    b_side_next.ys      = entry.ys;
    b_side_next.xe      = entry.xe;
    b_side_next.ye      = entry.ye;
  end

  side_t                      b_side;
  logic signed [2*DIFF_W-1:0] b_p1, b_p2, b_p3, b_p4;
  logic signed [2*MID_W-1:0]  b_dxsq, b_dysq;
  logic [LEN_W-1:0]           b_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_side.valid <= 1'b0;
    end else if (adv) begin
      b_side <= b_side_next;
      b_p1   <= pux * vx;
      b_p2   <= puy * vy;
      b_p3   <= pux * vy;
      b_p4   <= puy * vx;
      b_dxsq <= dx * dx;
      b_dysq <= dy * dy;
      b_d    <= d_abs;
    end
  end

  // Stage C: dot and cross products, cost sums
  side_t                   c_side;
  logic signed [DOT_W-1:0] c_dot, c_cr;
  logic [2*MID_W-1:0]      c_msum;
  logic [2*LEN_W-1:0]      c_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_side.valid <= 1'b0;
    end else if (adv) begin
      c_side <= b_side;
      c_dot  <= DOT_W'(b_p1) + DOT_W'(b_p2);
      c_cr   <= DOT_W'(b_p3) - DOT_W'(b_p4);
      c_msum <= $unsigned(b_dxsq) + $unsigned(b_dysq);
      c_dd   <= b_d * b_d;
    end
  end

  // Stage D: rounded costs and CORDIC start vector
  logic signed [DOT_W-1:0] cr_abs;
  logic [2*MID_W-1:0]      msum_r;
  logic [2*LEN_W-1:0]      dd_r;
  logic signed [XY_W-1:0]  x0, y0, dot_ext, cr_ext;
  logic signed [Z_W-1:0]   z0;
  carry_t                  d_carry;

  always_comb begin
    cr_abs  = c_cr[DOT_W-1] ? -c_cr : c_cr;
    dot_ext = {{(XY_W-DOT_W){c_dot[DOT_W-1]}}, c_dot};
    cr_ext  = {{(XY_W-DOT_W){cr_abs[DOT_W-1]}}, cr_abs};
    if (c_dot[DOT_W-1]) begin
      x0 = cr_ext;
      y0 = -dot_ext;
      z0 = Z_90;
    end else begin
      x0 = dot_ext;
      y0 = cr_ext;
      z0 = '0;
    end
    msum_r = c_msum + (2*MID_W)'(2);
    dd_r   = c_dd + (2*LEN_W)'(128);
    d_carry.side = c_side;
    d_carry.mc   = msum_r[COST_W+1:2];
    d_carry.lc   = dd_r[COST_W+7:8];
  end

  // CORDIC vectoring, one step per stage; entry 0 holds the start vector
  logic signed [XY_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1];
  carry_t                 cc [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] xn [CORDIC_STEPS];
  logic signed [XY_W-1:0] yn [CORDIC_STEPS];
  logic signed [Z_W-1:0]  zn [CORDIC_STEPS];

  always_comb begin
    logic signed [XY_W-1:0] xsh;
    logic signed [XY_W-1:0] ysh;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xsh = cx[i] >>> i;
      ysh = cy[i] >>> i;
      xn[i] = cx[i];
      yn[i] = cy[i];
      zn[i] = cz[i];
      if (!cy[i][XY_W-1] && cy[i] != '0) begin
        xn[i] = cx[i] + ysh;
        yn[i] = cy[i] - xsh;
        zn[i] = cz[i] + atan_deg(i);
      end else if (cy[i][XY_W-1]) begin
        xn[i] = cx[i] - ysh;
        yn[i] = cy[i] + xsh;
        zn[i] = cz[i] - atan_deg(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        cc[i].side.valid <= 1'b0;
      end
    end else if (adv) begin
      cx[0] <= x0;
      cy[0] <= y0;
      cz[0] <= z0;
      cc[0] <= d_carry;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cx[i+1] <= xn[i];
        cy[i+1] <= yn[i];
        cz[i+1] <= zn[i];
        cc[i+1] <= cc[i];
      end
    end
  end

  // Stage E: clamp the angle to half a turn
  carry_t            e_carry;
  logic [ZC_W-1:0]   e_zc;
  logic [ZC_W-1:0]   zc;

  always_comb begin
    if (cz[CORDIC_STEPS][Z_W-1]) begin
      zc = '0;
    end else if (cz[CORDIC_STEPS] > Z_180) begin
      zc = ZC_W'(Z_180);
    end else begin
      zc = cz[CORDIC_STEPS][ZC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_carry.side.valid <= 1'b0;
    end else if (adv) begin
      e_carry <= cc[CORDIC_STEPS];
      e_zc    <= zc;
    end
  end

  // Stage F: square the angle
  carry_t           f_carry;
  logic [2*ZC_W-1:0] f_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_carry.side.valid <= 1'b0;
    end else if (adv) begin
      f_carry <= e_carry;
      f_zz    <= e_zc * e_zc;
    end
  end

  // Stage G: round and test against the thresholds
  logic [2*ZC_W-1:0]  ac_sum;
  logic [ANGLE_W-1:0] ac;
  res_t               res_next;

  always_comb begin
    ac_sum = f_zz + (2*ZC_W)'(1 << (ROUND_SH - 1));
    ac     = ac_sum[ROUND_SH+ANGLE_W-1:ROUND_SH];
    res_next.valid   = f_carry.side.valid;
    res_next.end_tok = f_carry.side.end_tok;
    res_next.match   = !f_carry.side.zero && (ac < ang_thr) && (f_carry.mc < mid_thr);
    res_next.idx     = f_carry.side.idx;
    res_next.xs      = f_carry.side.xs;
    res_next.ys      = f_carry.side.ys;
    res_next.xe      = f_carry.side.xe;
    res_next.ye      = f_carry.side.ye;
    res_next.ac      = ac;
    res_next.mc      = f_carry.mc;
    res_next.lc      = f_carry.lc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res <= res_next;
    end
  end

endmodule

### rtl/core/line_segment_matcher_unit.sv
// Line segment matcher. Load: setup plus the 21-step square root of the
// segment length, then the store write. Probe: the square root of the probe
// length, then one store read per cycle over the stored segments plus an end
// token while the output word is free or being taken, then the compare pipeline
// and the output word; the next item is taken after the final result word leaves.
// Clear and unused codes do not leave the idle state.
// Reset (rst, synchronous): store empty, thresholds to defaults, no clearing pass.
module line_segment_matcher_unit #(
  parameter int MAX_LINES = lsm_pkg::MAX_LINES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,   // x_start, y_start, x_end, y_end
  input  logic [1:0]    s_tuser,   // operation
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [167:0]  m_tdata,   // entry_index, match_x_start, match_y_start,
                                   // match_x_end, match_y_end, angle_cost,
                                   // midpoint_cost, length_cost, zero pad
  output logic [0:0]    m_tuser,   // matched
  output logic          m_tlast,
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [33:0]   cfg_data
);
  import lsm_pkg::*;

  localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW = $clog2(MAX_LINES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_SQRT  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t             state;
  logic [CW-1:0]      seg_count;
  logic [CW-1:0]      sweep_idx;
  logic               is_probe;
  logic [COORD_W-1:0] cur_xs, cur_ys, cur_xe, cur_ye;
  logic signed [DIFF_W-1:0] cur_ux, cur_uy;
  logic               cur_zero;
  probe_t             probe_r;
  logic [ANGLE_W-1:0] ang_thr;
  logic [COST_W-1:0]  mid_thr;

  // Output word and the held match that may still be the last one
  res_t               hold;
  logic               hold_valid;
  res_t               out_res;
  logic               out_last;

  logic               adv;
  logic               in_acc;
  logic               issue, rd_issue, end_issue;
  logic               sq_start, sq_done;
  logic [LEN_W-1:0]   sq_root;
  logic [RAD_W-1:0]   radicand;
  logic               store_we;
  entry_t             store_wdata;
  entry_t             store_rdata;
  res_t               res;

  logic [COORD_W-1:0] in_xs, in_ys, in_xe, in_ye;
  logic signed [DIFF_W-1:0] in_ux, in_uy;
  logic signed [2*DIFF_W-1:0] sqx, sqy;
  logic [2*DIFF_W:0]  ssum;

  assign in_xs = s_tdata[15:0];
  assign in_ys = s_tdata[31:16];
  assign in_xe = s_tdata[47:32];
  assign in_ye = s_tdata[63:48];
  assign in_ux = $signed({1'b0, in_xs}) - $signed({1'b0, in_xe});
  assign in_uy = $signed({1'b0, in_ys}) - $signed({1'b0, in_ye});

  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Pipeline moves whenever the output word is free or being taken
  assign adv       = !m_tvalid || m_tready;
  assign issue     = (state == ST_SWEEP) && adv;
  assign rd_issue  = issue && (sweep_idx < seg_count);
  assign end_issue = issue && !(sweep_idx < seg_count);

  // Squared length, shifted for 4 fractional result bits
  assign sqx      = cur_ux * cur_ux;
  assign sqy      = cur_uy * cur_uy;
  assign ssum     = {1'b0, sqx} + {1'b0, sqy};
  assign radicand = RAD_W'({ssum, 8'b0});
  assign sq_start = (state == ST_PREP);

  assign store_we          = (state == ST_SQRT) && sq_done && !is_probe;
  assign store_wdata.xs    = cur_xs;
  assign store_wdata.ys    = cur_ys;
  assign store_wdata.xe    = cur_xe;
  assign store_wdata.ye    = cur_ye;
  assign store_wdata.len   = sq_root;
  assign store_wdata.zero  = cur_zero;

  lsm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  lsm_store #(
    .MAX_LINES (MAX_LINES),
    .AW        (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (seg_count[AW-1:0]),
    .wdata (store_wdata),
    .re    (rd_issue),
    .raddr (sweep_idx[AW-1:0]),
    .rdata (store_rdata)
  );

  lsm_match_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (rd_issue || end_issue),
    .in_end   (end_issue),
    .in_idx   (IDX_W'(sweep_idx)),
    .probe    (probe_r),
    .entry    (store_rdata),
    .ang_thr  (ang_thr),
    .mid_thr  (mid_thr),
    .res      (res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_count <= '0;
      sweep_idx <= '0;
      is_probe  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cur_xs   <= in_xs;
            cur_ys   <= in_ys;
            cur_xe   <= in_xe;
            cur_ye   <= in_ye;
            cur_ux   <= in_ux;
            cur_uy   <= in_uy;
            cur_zero <= (in_ux == '0) && (in_uy == '0);
            if (s_tuser == OP_CLEAR) begin
              seg_count <= '0;
            end else if (s_tuser == OP_LOAD) begin
              if (seg_count < CW'(MAX_LINES)) begin
                is_probe <= 1'b0;
                state    <= ST_PREP;
              end
            end else if (s_tuser == OP_PROBE) begin
              is_probe <= 1'b1;
              state    <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_done) begin
            if (is_probe) begin
              probe_r.ux   <= cur_ux;
              probe_r.uy   <= cur_uy;
              probe_r.sx   <= {1'b0, cur_xs} + {1'b0, cur_xe};
              probe_r.sy   <= {1'b0, cur_ys} + {1'b0, cur_ye};
              probe_r.len  <= sq_root;
              probe_r.zero <= cur_zero;
              sweep_idx    <= '0;
              state        <= ST_SWEEP;
            end else begin
              seg_count <= seg_count + 1'b1;
              state     <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          if (rd_issue) begin
            sweep_idx <= sweep_idx + 1'b1;
          end else if (end_issue) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (m_tvalid && m_tready && m_tlast) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ang_thr <= ANGLE_RESET;
      mid_thr <= MIDPOINT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ANGLE:    ang_thr <= cfg_data[ANGLE_W-1:0];
        CFG_MIDPOINT: mid_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result ordering: a match waits in hold until the next match or the end token
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b0;
      if (res.valid && res.end_tok) begin
        m_tvalid   <= 1'b1;
        out_last   <= 1'b1;
        out_res    <= hold_valid ? hold : '0;
        hold_valid <= 1'b0;
      end else if (res.valid && res.match) begin
        if (hold_valid) begin
          m_tvalid <= 1'b1;
          out_last <= 1'b0;
          out_res  <= hold;
        end
        hold       <= res;
        hold_valid <= 1'b1;
      end
    end
  end

  assign m_tdata = {7'b0, out_res.lc, out_res.mc, out_res.ac, out_res.ye, out_res.xe,
                    out_res.ys, out_res.xs, out_res.idx};
  assign m_tuser = out_res.match;
  assign m_tlast = out_last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CW'(MAX_LINES))
    else $error("segment count beyond capacity");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty result without last");

  a_match_in_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (out_res.idx < seg_count))
    else $error("match index outside stored segments");

  a_hold_in_probe: assert property (@(posedge clk) disable iff (rst)
    $rose(hold_valid) |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("match held outside a probe");

endmodule
